FILE: rtl/gccd_pkg.sv
package gccd_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned EDGE_W   = 31;
  localparam int unsigned CELLS_W  = 8;
  localparam int unsigned NODE_W   = 24;
  localparam int unsigned CORNER_W = 3;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SQRT_STAGES = 32;

  localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_CELL_EDGE = 3'd3,
    REG_INV_EDGE = 3'd4,
    REG_CELLS_X = 3'd5,
    REG_CELLS_Y = 3'd6,
    REG_CELLS_Z = 3'd7
  } cfg_reg_e;

endpackage

FILE: rtl/grid_cell_corner_distances_unit.sv
// Uniform grid cell corner distance unit.
// Input channel (valid_i/stall_o) takes one query point (signed fixed point,
// FRAC_BITS fraction bits). For each point the unit emits eight corner
// transactions on the output channel (valid_o/stall_i), corner 0 to 7, each
// with the linear node index and the saturated point-to-node distance; the
// eighth carries last_o.
// Throughput: one corner per cycle while the output is not stalled; the next
// point is taken in the cycle its predecessor's eighth corner is issued.
// The corner issue counter paces the input.
// Pipeline: the corners of an accepted point pass through 8 stages of cell
// lookup, node position and squares, then a 32-stage bit-per-stage square
// root and an output register.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// write only while the unit is idle. Reset restores origin 0, edge and
// inverse edge 1.0, and one cell per axis, and empties the pipeline.
// A stall while an output is valid freezes every stage; nothing is dropped or repeated.
module grid_cell_corner_distances_unit
  import gccd_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_AXIS = 255,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [NODE_W-1:0]    node_index_o,
  output logic [CORNER_W-1:0]  corner_o,
  output logic [DIST_W-1:0]    distance_o,
  output logic                 last_o
);

  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int unsigned EW = (NW > CELLS_W) ? NW : CELLS_W;
  localparam int unsigned PW = COORD_W + EDGE_W;
  localparam int unsigned HW = PW - 2 * FRAC_BITS;
  localparam int unsigned IW = 3 * NW + 2;
  localparam int unsigned XW = (IW > NODE_W) ? IW : NODE_W;
  localparam int unsigned EPW = EDGE_W + NW;
  localparam int unsigned DW = EPW + 2;

  // configuration registers
  logic signed [COORD_W-1:0] origin_q [3];
  logic [EDGE_W-1:0]  edge_q, inv_q;
  logic [CELLS_W-1:0] cells_q [3];
  logic [NW-1:0]      top_q [3];
  logic [NW:0]        sx_q;
  logic [2*NW+1:0]    sxy_q;
  logic [NW-1:0]      eff_d [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        cells_q[a]  <= CELLS_W'(1);
      end
      edge_q <= EDGE_W'(65536);
      inv_q  <= EDGE_W'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ORIGIN_X:  origin_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:  origin_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:  origin_q[2] <= cfg_data_i;
        REG_CELL_EDGE: edge_q <= cfg_data_i[EDGE_W-1:0];
        REG_INV_EDGE:  inv_q  <= cfg_data_i[EDGE_W-1:0];
        REG_CELLS_X:   cells_q[0] <= cfg_data_i[CELLS_W-1:0];
        REG_CELLS_Y:   cells_q[1] <= cfg_data_i[CELLS_W-1:0];
        REG_CELLS_Z:   cells_q[2] <= cfg_data_i[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cells_q[a] == '0) begin
        eff_d[a] = NW'(1);
      end else if (EW'(cells_q[a]) > EW'(MAX_CELLS_PER_AXIS)) begin
        eff_d[a] = NW'(MAX_CELLS_PER_AXIS);
      end else begin
        eff_d[a] = NW'(cells_q[a]);
      end
    end
  end

  // derived grid constants, settled long before any item reaches them
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      top_q[a] <= eff_d[a] - NW'(1);
    end
    sx_q  <= (NW+1)'(eff_d[0]) + (NW+1)'(1);
    sxy_q <= ((2*NW+2)'(eff_d[0]) + (2*NW+2)'(1)) *
             ((2*NW+2)'(eff_d[1]) + (2*NW+2)'(1));
  end

  // pipeline advance
  logic en;
  logic out_vld_q;
  assign en = !(out_vld_q && stall_i);

  // corner issue stage
  logic signed [COORD_W-1:0] pt_q [3];
  logic                pt_vld_q;
  logic [CORNER_W-1:0] cnt_q;
  logic                in_acc;

  assign stall_o = pt_vld_q && !(en && cnt_q == CORNER_LAST);
  assign in_acc  = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else if (in_acc) begin
      pt_vld_q <= 1'b1;
      cnt_q    <= '0;
    end else if (en && pt_vld_q) begin
      cnt_q <= cnt_q + CORNER_W'(1);
      if (cnt_q == CORNER_LAST) begin
        pt_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
    end
  end

  // stages 1..7
  logic [7:1] vld_q;
  logic [CORNER_W-1:0] cor_q [1:7];
  logic signed [COORD_W:0] diff1_q [3], diff2_q [3], diff3_q [3], diff4_q [3];
  logic [PW-1:0]       prod2_q [3];
  logic [NW-1:0]       n3_q [3];
  logic [NW-1:0]       n0_4_q;
  logic [EPW-1:0]      edn4_q [3];
  logic [XW-1:0]       t1_4_q, t2_4_q;
  logic signed [DW-1:0] d5_q [3];
  logic [NODE_W-1:0]   idx_q [5:7];
  logic [COORD_W-1:0]  m6_q [3];
  logic                sat6_q, sat7_q;
  logic [63:0]         sq7_q [3];

  logic [HW-1:0]       hi_d [3];
  logic [DW-1:0]       abs_d [3];
  logic                sat_d;
  logic [65:0]         sum_d;

  always_comb begin
    sat_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      hi_d[a]  = prod2_q[a][PW-1:2*FRAC_BITS];
      abs_d[a] = d5_q[a][DW-1] ? DW'(-d5_q[a]) : DW'(d5_q[a]);
      sat_d    = sat_d | (|abs_d[a][DW-1:COORD_W]);
    end
    sum_d = 66'(sq7_q[0]) + 66'(sq7_q[1]) + 66'(sq7_q[2]);
  end

  // square root pipeline, entry 0 is written by stage 8
  logic [SQRT_STAGES:0]  svld_q;
  logic [63:0]           rem_q  [0:SQRT_STAGES];
  logic [63:0]           root_q [0:SQRT_STAGES];
  logic [NODE_W-1:0]     sidx_q [0:SQRT_STAGES];
  logic [CORNER_W-1:0]   scor_q [0:SQRT_STAGES];
  logic [SQRT_STAGES:0]  ssat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      svld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[6:1], pt_vld_q};
      svld_q    <= {svld_q[SQRT_STAGES-1:0], vld_q[7]};
      out_vld_q <= svld_q[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        diff1_q[a] <= (COORD_W+1)'(pt_q[a]) - (COORD_W+1)'(origin_q[a]);
        diff2_q[a] <= diff1_q[a];
        prod2_q[a] <= diff1_q[a][COORD_W] ? '0 :
                      PW'(diff1_q[a][COORD_W-1:0]) * PW'(inv_q);
        diff3_q[a] <= diff2_q[a];
        n3_q[a]    <= ((hi_d[a] > HW'(top_q[a])) ? top_q[a] : hi_d[a][NW-1:0]) +
                      NW'(cor_q[2][a]);
        diff4_q[a] <= diff3_q[a];
        edn4_q[a]  <= EPW'(edge_q) * EPW'(n3_q[a]);
        d5_q[a]    <= DW'(diff4_q[a]) - DW'(edn4_q[a]);
        m6_q[a]    <= abs_d[a][COORD_W-1:0];
        sq7_q[a]   <= 64'(m6_q[a]) * 64'(m6_q[a]);
      end
      cor_q[1] <= cnt_q;
      for (int s = 2; s <= 7; s++) begin
        cor_q[s] <= cor_q[s-1];
      end
      n0_4_q <= n3_q[0];
      t1_4_q <= XW'(n3_q[1]) * XW'(sx_q);
      t2_4_q <= XW'(n3_q[2]) * XW'(sxy_q);
      idx_q[5] <= t2_4_q[NODE_W-1:0] + t1_4_q[NODE_W-1:0] + NODE_W'(n0_4_q);
      idx_q[6] <= idx_q[5];
      idx_q[7] <= idx_q[6];
      sat6_q   <= sat_d;
      sat7_q   <= sat6_q;
      rem_q[0]  <= sum_d[63:0];
      root_q[0] <= '0;
      ssat_q[0] <= sat7_q | (|sum_d[65:64]);
      sidx_q[0] <= idx_q[7];
      scor_q[0] <= cor_q[7];
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = root_q[k] + BIT;
    assign ge    = rem_q[k] >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= ge ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= ge ? (root_q[k] >> 1) + BIT : root_q[k] >> 1;
        ssat_q[k+1] <= ssat_q[k];
        sidx_q[k+1] <= sidx_q[k];
        scor_q[k+1] <= scor_q[k];
      end
    end
  end

  // output register
  logic [NODE_W-1:0]   out_idx_q;
  logic [CORNER_W-1:0] out_cor_q;
  logic [DIST_W-1:0]   out_dist_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q  <= sidx_q[SQRT_STAGES];
      out_cor_q  <= scor_q[SQRT_STAGES];
      out_dist_q <= ssat_q[SQRT_STAGES] ? '1 : root_q[SQRT_STAGES][DIST_W-1:0];
    end
  end

  assign valid_o      = out_vld_q;
  assign node_index_o = out_idx_q;
  assign corner_o     = out_cor_q;
  assign distance_o   = out_dist_q;
  assign last_o       = (out_cor_q == CORNER_LAST);

`ifndef SYNTHESIS
  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pt_vld_q && cnt_q == '0)
    else $error("accepted point did not restart corner issue");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> pt_vld_q)
    else $error("input stalled with no point in issue");

  a_hold_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_vld_q && !en && !in_acc |=> $stable(cnt_q))
    else $error("corner counter moved during output stall");
`endif

endmodule

FILE: sim/tb_grid_cell_corner_distances_unit.sv
`timescale 1ns / 1ps

module tb_grid_cell_corner_distances_unit;
  import gccd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned IDLE_PCT       = 27;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned RAND_POINTS    = 75;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [CORNER_W-1:0] corner;
    logic [DIST_W-1:0]   distance;
    logic                last;
  } corner_res_t;

  typedef struct {
    logic signed [COORD_W-1:0] px, py, pz;
    bit                        typed;
    logic [DIST_W-1:0]         dist_first;
    logic [DIST_W-1:0]         dist_last;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic signed [COORD_W-1:0] point_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [NODE_W-1:0] node_index_o;
  logic [CORNER_W-1:0] corner_o;
  logic [DIST_W-1:0] distance_o;
  logic last_o;

  // grid settings as the unit should hold them
  logic signed [COORD_W-1:0] grid_origin [3];
  logic [EDGE_W-1:0] cell_len;
  logic [EDGE_W-1:0] inv_len;
  logic [CELLS_W-1:0] grid_cells [3];

  corner_res_t corners_due [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit quiet_mode = 1'b0;
  bit hold_req = 1'b0;

  point_row_t directed_rows [8];

  grid_cell_corner_distances_unit u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_i, .stall_o, .point_x_i, .point_y_i, .point_z_i,
    .valid_o, .stall_i, .node_index_o, .corner_o, .distance_o, .last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CELLS_W-1:0] span_of(int a);
    return (grid_cells[a] == 0) ? 8'd1 : grid_cells[a];
  endfunction

  function automatic longint unsigned cell_of(logic signed [COORD_W-1:0] p, int a);
    longint diff, prod;
    longint unsigned idx;
    diff = longint'(p) - longint'(grid_origin[a]);
    prod = diff * longint'({1'b0, inv_len});
    if (prod < 0) return 0;
    idx = longint'(prod) >> (2 * 16);
    if (idx > span_of(a) - 1) idx = span_of(a) - 1;
    return idx;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] node_dist(logic signed [COORD_W-1:0] p [3],
                                                  longint unsigned n [3]);
    logic [63:0] sum, m, sq, r;
    longint pos, d;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      pos = longint'(grid_origin[a]) + longint'({1'b0, cell_len}) * longint'(n[a]);
      d = longint'(p[a]) - pos;
      m = (d < 0) ? -d : d;
      if (m > 64'hFFFF_FFFF) return '1;
      sq = m * m;
      if (sum > ~64'd0 - sq) return '1;
      sum = sum + sq;
    end
    r = root_floor(sum);
    return (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
  endfunction

  task automatic predict_corners(logic signed [COORD_W-1:0] px, py, pz, point_row_t row);
    logic signed [COORD_W-1:0] p [3];
    longint unsigned base [3], n [3];
    longint unsigned sx, sxy, idx;
    corner_res_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int a = 0; a < 3; a++) base[a] = cell_of(p[a], a);
    sx = span_of(0) + 1;
    sxy = sx * (span_of(1) + 1);
    for (int c = 0; c < 8; c++) begin
      n[0] = base[0] + c[0];
      n[1] = base[1] + c[1];
      n[2] = base[2] + c[2];
      idx = n[2] * sxy + n[1] * sx + n[0];
      r.node = idx[NODE_W-1:0];
      r.corner = c[CORNER_W-1:0];
      r.distance = node_dist(p, n);
      r.last = (r.corner == CORNER_LAST);
      if (row.typed && c == 0) r.distance = row.dist_first;
      if (row.typed && c == 7) r.distance = row.dist_last;
      corners_due = {corners_due, r};
    end
  endtask

  task automatic write_reg(cfg_reg_e r, logic [COORD_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_ORIGIN_X:  grid_origin[0] = d;
      REG_ORIGIN_Y:  grid_origin[1] = d;
      REG_ORIGIN_Z:  grid_origin[2] = d;
      REG_CELL_EDGE: cell_len = d[EDGE_W-1:0];
      REG_INV_EDGE:  inv_len = d[EDGE_W-1:0];
      REG_CELLS_X:   grid_cells[0] = d[CELLS_W-1:0];
      REG_CELLS_Y:   grid_cells[1] = d[CELLS_W-1:0];
      REG_CELLS_Z:   grid_cells[2] = d[CELLS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_grid(logic [31:0] ox, oy, oz, ce, ie, nx, ny, nz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_CELL_EDGE, ce);
    write_reg(REG_INV_EDGE, ie);
    write_reg(REG_CELLS_X, nx);
    write_reg(REG_CELLS_Y, ny);
    write_reg(REG_CELLS_Z, nz);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(logic signed [COORD_W-1:0] px, py, pz, point_row_t row);
    if (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 50);
    end
    valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do @(posedge clk_i); while (stall_o);
    predict_corners(px, py, pz, row);
  endtask

  task automatic drain_corners();
    valid_i <= 1'b0;
    while (corners_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // point near the grid most of the time, anywhere otherwise
  function automatic logic [31:0] pick_coord(int a, bit near);
    longint span;
    if (!near) return $urandom;
    span = longint'({1'b0, cell_len}) * (longint'(span_of(a)) + 2);
    return 32'(longint'(grid_origin[a]) - longint'({1'b0, cell_len}) +
               longint'({$urandom, $urandom} % (span + 1)));
  endfunction

  task automatic random_grid();
    int k;
    if ($urandom_range(0, 3) != 0) begin
      k = $urandom_range(8, 20);
      write_grid($urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 21) - (1 << 20),
                 $urandom_range(0, 1 << 21) - (1 << 20), 1 << k, 1 << (32 - k),
                 $urandom_range(1, 12), $urandom_range(1, 12),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6));
    end else begin
      write_grid($urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_points(int unsigned count);
    point_row_t none;
    bit near;
    none = '{default: '0};
    for (int unsigned i = 0; i < count; i++) begin
      near = ($urandom_range(0, 9) < 8);
      send_point(pick_coord(0, near), pick_coord(1, near), pick_coord(2, near), none);
    end
    drain_corners();
  endtask

  // output side: compare each transaction, then pick the next stall
  initial begin
    corner_res_t want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) begin
        if (corners_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected corner: node %0d corner %0d dist %0h",
                     node_index_o, corner_o, distance_o);
        end else begin
          want = corners_due.pop_front();
          if (want.node !== node_index_o || want.corner !== corner_o ||
              want.distance !== distance_o || want.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"corner mismatch: exp node %0d corner %0d dist %0h last %0b,",
                        " got %0d %0d %0h %0b"},
                       want.node, want.corner, want.distance, want.last,
                       node_index_o, corner_o, distance_o, last_o);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    grid_origin = '{default: '0};
    grid_cells = '{default: 8'd1};
    cell_len = 31'd65536;
    inv_len = 31'd65536;
    // reset grid: one unit cell at the origin
    directed_rows[0] = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 32'd0, 32'd113511};
    directed_rows[1] = '{32'sd65536, 32'sd0, 32'sd0, 1'b1, 32'd65536, 32'd92681};
    directed_rows[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0, '0};
    directed_rows[3] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0, '0};
    directed_rows[4] = '{-32'sd1, 32'sd32768, 32'sd65535, 1'b0, '0, '0};
    directed_rows[5] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b0, '0, '0};
    directed_rows[6] = '{32'sh5555_5555, 32'shAAAA_AAAA, -32'sd65536, 1'b0, '0, '0};
    directed_rows[7] = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sd131072, 1'b0, '0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                 directed_rows[i]);
    drain_corners();

    // zero cell counts, zero edge and zero inverse edge
    write_grid(0, 0, 0, 0, 0, 0, 0, 0);
    random_points(8);

    // extremes: far origins, widest cells, largest grid; hold the output meanwhile
    write_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               255, 255, 255);
    hold_req = 1'b1;
    random_points(12);

    // small cells over the largest grid reach the top node indexes
    write_grid(0, 0, 0, 32'd256, 32'd16777216, 255, 255, 255);
    random_points(12);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiet_mode = (ph == 2);
      random_grid();
      random_points(RAND_POINTS);
    end
    quiet_mode = 1'b0;

    if (mismatches == 0 && corners_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gccd_pkg.sv
rtl/grid_cell_corner_distances_unit.sv
sim/tb_grid_cell_corner_distances_unit.sv
